@@ design/fsd_pkg.sv @@
// Package for the fault symptom debouncer: item types, codes and defaults.
`default_nettype none
package fsd_pkg;

  // Default sizes of the fault table
  localparam int NUM_FAULTS_DEF   = 8;
  localparam int COUNTER_BITS_DEF = 16;

  // Action codes
  localparam logic [1:0] ACT_CONFIG   = 2'd0;
  localparam logic [1:0] ACT_DEBOUNCE = 2'd1;
  localparam logic [1:0] ACT_RESET    = 2'd2;
  localparam logic [1:0] ACT_MASK     = 2'd3;

  // Debounce state codes as stored and reported
  localparam logic [2:0] ST_PASS  = 3'd0;
  localparam logic [2:0] ST_SYM   = 3'd1;
  localparam logic [2:0] ST_NOSYM = 3'd2;
  localparam logic [2:0] ST_FAILU = 3'd3;
  localparam logic [2:0] ST_FAILS = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  fault_index;
    logic        symptom;
    logic [15:0] step_up;
    logic [15:0] step_down;
    logic [15:0] count_limit;
    logic [7:0]  mask_value;
  } in_item_t;

  typedef struct packed {
    logic        failing;
    logic [2:0]  fault_state;
    logic [15:0] fault_count;
    logic [7:0]  global_mask;
    logic        index_error;
  } out_item_t;

endpackage
`default_nettype wire

@@ design/fault_symptom_debouncer.sv @@
// Top level of the fault symptom debouncer: fault table, debounce step, item pipeline.
//
// Usage: items enter on in_valid/in_ready/in_data and each one yields exactly one
// result item on out_valid/out_ready/out_data, in order. An item selects one of
// four actions: configure a fault entry (load step up, step down and limit, clear
// it), debounce one symptom sample, reset one fault entry, or write the global
// 8-bit fault mask. Every result reports the addressed entry's fail flag, state
// and count after the step, the global mask and an index error flag.
// Pipeline: an accepted item is latched in the input register, its table update
// and result are computed from there and land in the result register; out_valid
// is high from then on. Throughput is one item per cycle while out_ready is high,
// set by a single table read, saturating add or subtract and compare between the
// input register and the result register.
// Reset (rst_n low, synchronous): every entry goes to pass with count, steps and
// limit at zero, the mask is cleared and both pipeline registers are emptied.
// Receiver stall: the result register holds its item while out_ready is low; the
// input register still takes one more item, then in_ready drops until the
// result is taken.
`default_nettype none
module fault_symptom_debouncer #(
  parameter int NUM_FAULTS   = fsd_pkg::NUM_FAULTS_DEF,
  parameter int COUNTER_BITS = fsd_pkg::COUNTER_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire fsd_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output fsd_pkg::out_item_t     out_data
);
  import fsd_pkg::*;

  localparam int IDX_W = (NUM_FAULTS > 1) ? $clog2(NUM_FAULTS) : 1;
  localparam logic [3:0] NF_L = 4'(NUM_FAULTS);

  typedef logic [COUNTER_BITS-1:0] cnt_t;

  // Fault table
  cnt_t       su_r  [NUM_FAULTS];
  cnt_t       sd_r  [NUM_FAULTS];
  cnt_t       lim_r [NUM_FAULTS];
  cnt_t       cnt_r [NUM_FAULTS];
  logic [2:0] st_r  [NUM_FAULTS];
  logic [7:0] mask_r;

  // Pipeline registers
  in_item_t  s1_r;
  logic      s1_valid_r;
  out_item_t out_r;
  logic      out_valid_r;

  logic            s1_adv;
  logic            idx_ok;
  logic [IDX_W-1:0] ent;
  cnt_t            cur_cnt, lim, su, sd, up_val, dn_val;
  logic [2:0]      cur_st;
  logic [7:0]      bit_sel;
  cnt_t            cnt_nxt;
  logic [2:0]      st_nxt;
  logic [7:0]      mask_nxt;
  logic            ent_we;
  out_item_t       out_nxt;

  // Flow control
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Entry read
  always_comb begin
    idx_ok  = {1'b0, s1_r.fault_index} < NF_L;
    ent     = idx_ok ? s1_r.fault_index[IDX_W-1:0] : '0;
    cur_cnt = cnt_r[ent];
    lim     = lim_r[ent];
    su      = su_r[ent];
    sd      = sd_r[ent];
    cur_st  = st_r[ent];
    bit_sel = 8'b1 << s1_r.fault_index;
  end

  // Saturating count up and down
  always_comb begin
    if (cur_cnt >= lim || (lim - cur_cnt) < su) begin
      up_val = lim;
    end else begin
      up_val = cur_cnt + su;
    end
    if (sd > cur_cnt) begin
      dn_val = '0;
    end else begin
      dn_val = cur_cnt - sd;
    end
  end

  // Action and debounce step
  always_comb begin
    cnt_nxt  = cur_cnt;
    st_nxt   = cur_st;
    mask_nxt = mask_r;
    ent_we   = 1'b0;
    case (s1_r.action)
      ACT_MASK: begin
        mask_nxt = s1_r.mask_value;
      end
      ACT_CONFIG, ACT_RESET: begin
        ent_we  = idx_ok;
        cnt_nxt = '0;
        st_nxt  = ST_PASS;
      end
      ACT_DEBOUNCE: begin
        ent_we = idx_ok;
        case (cur_st)
          ST_PASS: begin
            if (s1_r.symptom) begin
              cnt_nxt = up_val;
              if (up_val == lim) begin
                st_nxt = ST_FAILU;
                if (idx_ok) mask_nxt = mask_r | bit_sel;
              end else begin
                st_nxt = ST_SYM;
              end
            end
          end
          ST_SYM: begin
            if (!s1_r.symptom) begin
              cnt_nxt = dn_val;
              st_nxt  = ST_NOSYM;
            end else begin
              cnt_nxt = up_val;
              if (up_val == lim) begin
                st_nxt = ST_FAILU;
                if (idx_ok) mask_nxt = mask_r | bit_sel;
              end
            end
          end
          ST_NOSYM: begin
            if (s1_r.symptom) begin
              cnt_nxt = up_val;
              if (up_val == lim) begin
                st_nxt = ST_FAILU;
                if (idx_ok) mask_nxt = mask_r | bit_sel;
              end else begin
                st_nxt = ST_SYM;
              end
            end else begin
              cnt_nxt = dn_val;
            end
            // zero count returns to pass, mask bit stays
            if (cnt_nxt == '0) st_nxt = ST_PASS;
          end
          ST_FAILU, ST_FAILS: begin
            if (s1_r.symptom) begin
              cnt_nxt = up_val;
              if (idx_ok) mask_nxt = mask_r | bit_sel;
            end else begin
              cnt_nxt = dn_val;
            end
            // zero count heals the fault and clears its mask bit
            if (cnt_nxt == '0) begin
              st_nxt = ST_PASS;
              if (idx_ok) mask_nxt = mask_nxt & ~bit_sel;
            end
          end
          default: begin
            st_nxt = ST_PASS;
          end
        endcase
      end
      default: begin
        mask_nxt = mask_r;
      end
    endcase
  end

  // Result item
  always_comb begin
    out_nxt.failing     = idx_ok && (st_nxt == ST_FAILU || st_nxt == ST_FAILS);
    out_nxt.fault_state = idx_ok ? st_nxt : ST_PASS;
    out_nxt.fault_count = idx_ok ? 16'(cnt_nxt) : 16'd0;
    out_nxt.global_mask = mask_nxt;
    out_nxt.index_error = !idx_ok;
  end

  // Table and mask update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_FAULTS; i++) begin
        su_r[i]  <= '0;
        sd_r[i]  <= '0;
        lim_r[i] <= '0;
        cnt_r[i] <= '0;
        st_r[i]  <= ST_PASS;
      end
      mask_r <= '0;
    end else if (s1_adv) begin
      mask_r <= mask_nxt;
      if (ent_we) begin
        cnt_r[ent] <= cnt_nxt;
        st_r[ent]  <= st_nxt;
        if (s1_r.action == ACT_CONFIG) begin
          su_r[ent]  <= s1_r.step_up[COUNTER_BITS-1:0];
          sd_r[ent]  <= s1_r.step_down[COUNTER_BITS-1:0];
          lim_r[ent] <= s1_r.count_limit[COUNTER_BITS-1:0];
        end
      end
    end
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_r <= in_data;
    if (s1_adv) out_r <= out_nxt;
  end

  // Checks
  a_idx_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.index_error |->
      !out_r.failing && out_r.fault_state == ST_PASS && out_r.fault_count == 16'd0)
    else $error("index error result carries fault data");

  a_fail_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      out_r.failing == (out_r.fault_state == ST_FAILU || out_r.fault_state == ST_FAILS))
    else $error("fail flag disagrees with state");

  a_mask_write: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_r.action == ACT_MASK |=> mask_r == $past(s1_r.mask_value))
    else $error("mask write lost");

  for (genvar g = 0; g < NUM_FAULTS; g++) begin : g_chk
    a_cnt_le_lim: assert property (@(posedge clk) disable iff (!rst_n)
      cnt_r[g] <= lim_r[g])
      else $error("counter above limit");
  end

endmodule
`default_nettype wire

@@ bench/fsd_checker.sv @@
// Fault symptom debouncer checker: mirrors the fault table and compares every result item.
module fsd_checker #(
  parameter int NUM_FAULTS = fsd_pkg::NUM_FAULTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire fsd_pkg::in_item_t  in_data,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire fsd_pkg::out_item_t out_data,
  output int                      err_count,
  output int                      pending
);
  import fsd_pkg::*;

  // Mirrored fault table and global mask
  logic [15:0] up_tbl    [NUM_FAULTS];
  logic [15:0] down_tbl  [NUM_FAULTS];
  logic [15:0] lim_tbl   [NUM_FAULTS];
  logic [15:0] cnt_tbl   [NUM_FAULTS];
  logic [2:0]  state_tbl [NUM_FAULTS];
  logic [7:0]  mask_q;

  // Predicted result items, oldest first
  out_item_t   result_q [$];
  out_item_t   want_item;
  out_item_t   next_item;

  initial begin
    err_count = 0;
    pending   = 0;
  end

  // Saturating moves of one fault counter
  task automatic count_up(input int i);
    if (cnt_tbl[i] >= lim_tbl[i] || (lim_tbl[i] - cnt_tbl[i]) < up_tbl[i])
      cnt_tbl[i] = lim_tbl[i];
    else
      cnt_tbl[i] = cnt_tbl[i] + up_tbl[i];
  endtask

  task automatic count_down(input int i);
    if (down_tbl[i] > cnt_tbl[i])
      cnt_tbl[i] = '0;
    else
      cnt_tbl[i] = cnt_tbl[i] - down_tbl[i];
  endtask

  // Up-count that may reach the limit and declare the fault
  task automatic rise_to_fail(input int i, input bit keep_on_miss);
    count_up(i);
    if (cnt_tbl[i] == lim_tbl[i]) begin
      state_tbl[i] = ST_FAILU;
      mask_q[i]    = 1'b1;
    end else if (!keep_on_miss) begin
      state_tbl[i] = ST_SYM;
    end
  endtask

  // One debounce sample on one entry
  task automatic debounce_fault(input int i, input logic sym);
    case (state_tbl[i])
      ST_PASS: begin
        if (sym)
          rise_to_fail(i, 1'b0);
      end
      ST_SYM: begin
        if (!sym) begin
          count_down(i);
          state_tbl[i] = ST_NOSYM;
        end else begin
          rise_to_fail(i, 1'b1);
        end
      end
      ST_NOSYM: begin
        if (sym)
          rise_to_fail(i, 1'b0);
        else
          count_down(i);
        if (cnt_tbl[i] == '0)
          state_tbl[i] = ST_PASS;
      end
      ST_FAILU, ST_FAILS: begin
        if (!sym) begin
          count_down(i);
        end else begin
          count_up(i);
          mask_q[i] = 1'b1;
        end
        if (cnt_tbl[i] == '0) begin
          state_tbl[i] = ST_PASS;
          mask_q[i]    = 1'b0;
        end
      end
      default: state_tbl[i] = ST_PASS;
    endcase
  endtask

  // Apply one item to the mirror and form its result
  task automatic step_fault(input in_item_t it, output out_item_t res);
    int  idx;
    bit  idx_ok;
    idx    = int'(it.fault_index);
    idx_ok = idx < NUM_FAULTS;
    if (it.action == ACT_MASK) begin
      mask_q = it.mask_value;
    end else if (idx_ok) begin
      case (it.action)
        ACT_CONFIG: begin
          up_tbl[idx]    = it.step_up;
          down_tbl[idx]  = it.step_down;
          lim_tbl[idx]   = it.count_limit;
          cnt_tbl[idx]   = '0;
          state_tbl[idx] = ST_PASS;
        end
        ACT_DEBOUNCE: debounce_fault(idx, it.symptom);
        default: begin
          cnt_tbl[idx]   = '0;
          state_tbl[idx] = ST_PASS;
        end
      endcase
    end
    res = '0;
    if (idx_ok) begin
      res.fault_state = state_tbl[idx];
      res.failing     = (state_tbl[idx] == ST_FAILU) || (state_tbl[idx] == ST_FAILS);
      res.fault_count = cnt_tbl[idx];
    end else begin
      res.index_error = 1'b1;
    end
    res.global_mask = mask_q;
  endtask

  // Retire results first, then predict; a result never leaves at its own accept edge
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_FAULTS; i++) begin
        up_tbl[i]    = '0;
        down_tbl[i]  = '0;
        lim_tbl[i]   = '0;
        cnt_tbl[i]   = '0;
        state_tbl[i] = ST_PASS;
      end
      mask_q = '0;
      result_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          err_count = err_count + 1;
          if (err_count <= 10)
            $display("fsd_checker: result item with nothing pending: %p", out_data);
        end else begin
          want_item = result_q.pop_front();
          if (out_data !== want_item) begin
            err_count = err_count + 1;
            // fields: fail/state/count/mask/ierr
            if (err_count <= 10)
              $display("fsd_checker: mismatch exp %b/%0d/%h/%h/%b got %b/%0d/%h/%h/%b",
                       want_item.failing, want_item.fault_state, want_item.fault_count,
                       want_item.global_mask, want_item.index_error,
                       out_data.failing, out_data.fault_state, out_data.fault_count,
                       out_data.global_mask, out_data.index_error);
          end
        end
      end
      if (in_valid && in_ready) begin
        step_fault(in_data, next_item);
        result_q.push_back(next_item);
      end
    end
    pending = result_q.size();
  end

endmodule

@@ bench/tb_fault_symptom_debouncer.sv @@
// Testbench top for the fault symptom debouncer: clock, reset, stimulus and verdict.
module tb_fault_symptom_debouncer;
  import fsd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;

  int err_count;
  int pending;
  int cycles        = 0;
  int send_idle_pct = 9;
  int recv_idle_pct = 74;
  int sym_bias      = 50;

  fault_symptom_debouncer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  fsd_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .err_count (err_count),
    .pending   (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Receiver stalls at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_fault_symptom_debouncer: done, errors");
      $finish;
    end
  end

  // Build one item; a negative step, limit or mask argument becomes random noise
  function automatic in_item_t mk_item(input logic [1:0] act, input int idx, input logic sym,
                                       input int su, input int sd, input int lim,
                                       input int msk);
    in_item_t it;
    it.action      = act;
    it.fault_index = idx[2:0];
    it.symptom     = sym;
    it.step_up     = (su  < 0) ? 16'($urandom) : su[15:0];
    it.step_down   = (sd  < 0) ? 16'($urandom) : sd[15:0];
    it.count_limit = (lim < 0) ? 16'($urandom) : lim[15:0];
    it.mask_value  = (msk < 0) ? 8'($urandom)  : msk[7:0];
    return it;
  endfunction

  // Mostly debounce runs on small counters, with configure, reset and mask writes mixed in
  function automatic in_item_t rand_item();
    int       pick;
    logic [1:0] act;
    bit       wide;
    pick = $urandom_range(0, 99);
    wide = ($urandom_range(0, 99) < 15);
    if ($urandom_range(0, 29) == 0)
      sym_bias = 25 * $urandom_range(1, 3);
    if (pick < 70)
      act = ACT_DEBOUNCE;
    else if (pick < 82)
      act = ACT_CONFIG;
    else if (pick < 90)
      act = ACT_RESET;
    else
      act = ACT_MASK;
    if (act == ACT_CONFIG && !wide)
      return mk_item(act, $urandom_range(0, 7), 1'($urandom), $urandom_range(0, 6),
                     $urandom_range(0, 6), $urandom_range(0, 24), -1);
    return mk_item(act, $urandom_range(0, 7), ($urandom_range(0, 99) < sym_bias),
                   -1, -1, -1, -1);
  endfunction

  // Offer one item and hold it until taken; called and returns at a falling edge
  task automatic send_item(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Hold off the sender until every result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: mask extremes, normal climb to fail and one step down, full-scale values
    send_item(mk_item(ACT_MASK, 7, 1'b0, 0, 0, 0, 8'hFF));
    send_item(mk_item(ACT_MASK, 0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00));
    send_item(mk_item(ACT_CONFIG, 0, 1'b0, 1, 1, 3, 0));
    repeat (4) send_item(mk_item(ACT_DEBOUNCE, 0, 1'b1, 0, 0, 0, 0));
    send_item(mk_item(ACT_DEBOUNCE, 0, 1'b0, 0, 0, 0, 0));
    send_item(mk_item(ACT_CONFIG, 1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_item(mk_item(ACT_DEBOUNCE, 1, 1'b1, 0, 0, 0, 0));
    send_item(mk_item(ACT_DEBOUNCE, 1, 1'b0, 0, 0, 0, 0));
    // Zero limit: fails on the first symptom, zero count then returns to pass
    send_item(mk_item(ACT_CONFIG, 2, 1'b0, 5, 2, 0, 0));
    repeat (2) send_item(mk_item(ACT_DEBOUNCE, 2, 1'b1, 0, 0, 0, 0));
    // Zero increment: symptom without counting, then no symptom back to pass
    send_item(mk_item(ACT_CONFIG, 3, 1'b0, 0, 3, 5, 0));
    send_item(mk_item(ACT_DEBOUNCE, 3, 1'b1, 0, 0, 0, 0));
    repeat (2) send_item(mk_item(ACT_DEBOUNCE, 3, 1'b0, 0, 0, 0, 0));
    // Never configured entry, reset of a failed entry, mask write
    send_item(mk_item(ACT_DEBOUNCE, 4, 1'b0, 0, 0, 0, 0));
    send_item(mk_item(ACT_DEBOUNCE, 4, 1'b1, 0, 0, 0, 0));
    send_item(mk_item(ACT_RESET, 4, 1'b1, 0, 0, 0, 0));
    send_item(mk_item(ACT_MASK, 3, 1'b0, 0, 0, 0, 8'hA5));
    send_item(mk_item(ACT_RESET, 0, 1'b0, 0, 0, 0, 0));
    send_item(mk_item(ACT_DEBOUNCE, 0, 1'b0, 0, 0, 0, 0));
    drain_results();

    // Random: three idling profiles, with a full drain halfway through the first
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 74 : 0;
      recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 9 : 0;
      for (int n = 0; n < 340; n++) begin
        if (phase == 0 && n == 170)
          drain_results();
        send_item(rand_item());
      end
    end

    // Wind down
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
    if (err_count == 0 && pending == 0)
      $display("tb_fault_symptom_debouncer: done, clean");
    else
      $display("tb_fault_symptom_debouncer: done, errors");
    $finish;
  end

endmodule

@@ sim.f @@
design/fsd_pkg.sv
design/fault_symptom_debouncer.sv
bench/fsd_checker.sv
bench/tb_fault_symptom_debouncer.sv
